### sv/lobm_pkg.sv
// lobm_pkg: shared types and constants of the limit order book matcher
// used by lobm_cell and limit_order_book_matcher; no dependencies
package lobm_pkg;

    localparam int PRODUCTS_DEF   = 8;
    localparam int BOOK_DEPTH_DEF = 32;

    // slot index width sized for the largest supported book depth (1024)
    localparam int IDX_W = 10;

    localparam int PRICE_W = 16;
    localparam int QTY_W   = 20;
    localparam int ID_W    = 16;
    localparam int ARR_W   = 32;

    localparam logic [1:0] ST_FILL   = 2'd0;
    localparam logic [1:0] ST_RESTED = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    // best-so-far token passed from cell to cell
    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   idx;
        logic [PRICE_W-1:0] price;
        logic [ARR_W-1:0]   age;
        logic [QTY_W-1:0]   qty;
        logic [ID_W-1:0]    id;
        logic               free_found;
        logic [IDX_W-1:0]   free_idx;
    } link_t;

    // command broadcast from the sequencer to every cell
    typedef struct packed {
        logic               ld;
        logic               opp_ask;
        logic [ARR_W-1:0]   now;
        logic               fill_we;
        logic               fill_clear;
        logic [IDX_W-1:0]   fill_idx;
        logic [QTY_W-1:0]   fill_qty;
        logic               rest_we;
        logic [IDX_W-1:0]   rest_idx;
        logic [PRICE_W-1:0] rest_price;
        logic [QTY_W-1:0]   rest_qty;
        logic [ID_W-1:0]    rest_id;
    } cmd_t;

endpackage

### sv/limit_order_book_matcher.sv
// limit_order_book_matcher: price-time priority matcher, sequencer and cell row
// depends on lobm_pkg and lobm_cell
//
//   channel  dir  handshake            payload
//   in       in   in_valid / in_ready  product side price quantity order_id
//   out      out  out_valid/out_ready  product_res status fill_quantity ask_id
//                                      bid_id last
//
// one order at a time; each search of the opposite book runs the token down
// the row of BOOK_DEPTH cells; the first search of an order follows a load step
// each fill that leaves quantity starts a further search without a reload; out stalls hold it
// a rejected order (bad product, zero quantity) goes straight to out, held while out stalls
// reset clears the valid bits of every slot and the arrival counter; no sweep
module limit_order_book_matcher #(
    parameter int PRODUCTS   = lobm_pkg::PRODUCTS_DEF,
    parameter int BOOK_DEPTH = lobm_pkg::BOOK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  product,
    input  logic        side,
    input  logic [15:0] price,
    input  logic [19:0] quantity,
    input  logic [15:0] order_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  product_res,
    output logic [1:0]  status,
    output logic [19:0] fill_quantity,
    output logic [15:0] ask_id,
    output logic [15:0] bid_id,
    output logic        last
);
    localparam int PW  = (PRODUCTS > 1) ? $clog2(PRODUCTS) : 1;
    localparam int CW  = $clog2(BOOK_DEPTH + 1);

    typedef enum logic [2:0] {IDLE, LOAD, SEARCH, DECIDE, OUT} state_t;

    state_t                        state_reg;
    logic [CW-1:0]                 cnt_reg;
    logic [lobm_pkg::ARR_W-1:0]    arrival_reg;
    logic [lobm_pkg::ARR_W-1:0]    now_reg;
    logic [2:0]                    product_reg;
    logic                          side_reg;
    logic [15:0]                   price_reg;
    logic [19:0]                   qty_reg;
    logic [15:0]                   oid_reg;

    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [19:0] fill_q_reg;
    logic [15:0] ask_id_reg;
    logic [15:0] bid_id_reg;
    logic        last_reg;

    lobm_pkg::cmd_t  cmd;
    lobm_pkg::link_t links [BOOK_DEPTH+1];
    lobm_pkg::link_t best;

    logic [6:0]  prod_ext;
    logic [PW:0] addr_opp;
    logic [PW:0] addr_own;
    logic        in_ok;
    logic        crosses;
    logic        match;
    logic [19:0] fill_q;
    logic [19:0] left_q;

    assign prod_ext = 7'(product_reg);
    assign addr_opp = {~side_reg, prod_ext[PW-1:0]};
    assign addr_own = {side_reg, prod_ext[PW-1:0]};
    assign in_ok    = (7'(product) < 7'(PRODUCTS)) && (quantity != 20'd0);

    assign best    = links[BOOK_DEPTH];
    assign crosses = side_reg ? (best.price >= price_reg) : (price_reg >= best.price);
    assign match   = best.found && crosses;
    assign fill_q  = (best.qty < qty_reg) ? best.qty : qty_reg;
    assign left_q  = qty_reg - fill_q;

    always_comb
    begin
        cmd            = '0;
        cmd.ld         = (state_reg == LOAD);
        cmd.opp_ask    = ~side_reg;
        cmd.now        = now_reg;
        cmd.fill_we    = (state_reg == DECIDE) && match;
        cmd.fill_clear = (best.qty == fill_q);
        cmd.fill_idx   = best.idx;
        cmd.fill_qty   = best.qty - fill_q;
        cmd.rest_we    = (state_reg == DECIDE) && !match && best.free_found;
        cmd.rest_idx   = best.free_idx;
        cmd.rest_price = price_reg;
        cmd.rest_qty   = qty_reg;
        cmd.rest_id    = oid_reg;
    end

    assign links[0] = '0;

    for (genvar g = 0; g < BOOK_DEPTH; g++)
    begin : g_cell
        lobm_cell #(
            .PRODUCTS (PRODUCTS),
            .SLOT     (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .addr_opp (addr_opp),
            .addr_own (addr_own),
            .link_in  (links[g]),
            .link_out (links[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            cnt_reg       <= '0;
            arrival_reg   <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                IDLE:
                begin
                    if (in_valid)
                    begin
                        product_reg <= product;
                        side_reg    <= side;
                        price_reg   <= price;
                        qty_reg     <= quantity;
                        oid_reg     <= order_id;
                        now_reg     <= arrival_reg;
                        arrival_reg <= arrival_reg + 1'b1;
                        if (in_ok)
                            state_reg <= LOAD;
                        else
                        begin
                            status_reg    <= lobm_pkg::ST_REJECT;
                            fill_q_reg    <= '0;
                            ask_id_reg    <= side ? order_id : 16'd0;
                            bid_id_reg    <= side ? 16'd0 : order_id;
                            last_reg      <= 1'b1;
                            out_valid_reg <= 1'b1;
                            state_reg     <= OUT;
                        end
                    end
                end
                LOAD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= SEARCH;
                end
                SEARCH:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(BOOK_DEPTH))
                        state_reg <= DECIDE;
                end
                DECIDE:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= OUT;
                    if (match)
                    begin
                        status_reg <= lobm_pkg::ST_FILL;
                        fill_q_reg <= fill_q;
                        ask_id_reg <= side_reg ? oid_reg : best.id;
                        bid_id_reg <= side_reg ? best.id : oid_reg;
                        last_reg   <= (left_q == 20'd0);
                        qty_reg    <= left_q;
                    end
                    else
                    begin
                        status_reg <= best.free_found ? lobm_pkg::ST_RESTED
                                                      : lobm_pkg::ST_REJECT;
                        fill_q_reg <= '0;
                        ask_id_reg <= side_reg ? oid_reg : 16'd0;
                        bid_id_reg <= side_reg ? 16'd0 : oid_reg;
                        last_reg   <= 1'b1;
                    end
                end
                OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        cnt_reg       <= '0;
                        // entries are already loaded, only the chain needs to settle
                        state_reg     <= last_reg ? IDLE : SEARCH;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign in_ready      = (state_reg == IDLE);
    assign out_valid     = out_valid_reg;
    assign product_res   = product_reg;
    assign status        = status_reg;
    assign fill_quantity = fill_q_reg;
    assign ask_id        = ask_id_reg;
    assign bid_id        = bid_id_reg;
    assign last          = last_reg;

    a_out_in_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == OUT))
        else $error("result shown outside the handoff state");
    a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("request taken while a result waits");
    a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == lobm_pkg::ST_FILL) |-> (fill_quantity != 20'd0))
        else $error("empty fill");
    a_notice_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != lobm_pkg::ST_FILL) |-> last)
        else $error("notice not marked last");

endmodule

### sv/lobm_cell.sv
// lobm_cell: one book slot for every product and side, plus one stage of the
// best-entry and free-slot search chain; depends on lobm_pkg
module lobm_cell #(
    parameter int PRODUCTS = lobm_pkg::PRODUCTS_DEF,
    parameter int SLOT     = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lobm_pkg::cmd_t                    cmd,
    input  logic [((PRODUCTS > 1) ? $clog2(PRODUCTS) : 1):0] addr_opp,
    input  logic [((PRODUCTS > 1) ? $clog2(PRODUCTS) : 1):0] addr_own,
    input  lobm_pkg::link_t                   link_in,
    output lobm_pkg::link_t                   link_out
);
    localparam int PW    = (PRODUCTS > 1) ? $clog2(PRODUCTS) : 1;
    localparam int ADDRS = 2 ** (PW + 1);

    logic [lobm_pkg::PRICE_W-1:0] price_mem [ADDRS];
    logic [lobm_pkg::QTY_W-1:0]   qty_mem   [ADDRS];
    logic [lobm_pkg::ID_W-1:0]    id_mem    [ADDRS];
    logic [lobm_pkg::ARR_W-1:0]   arr_mem   [ADDRS];

    logic [ADDRS-1:0] valid_reg;

    logic [lobm_pkg::PRICE_W-1:0] cur_price_reg;
    logic [lobm_pkg::QTY_W-1:0]   cur_qty_reg;
    logic [lobm_pkg::ID_W-1:0]    cur_id_reg;
    logic [lobm_pkg::ARR_W-1:0]   cur_arr_reg;

    lobm_pkg::link_t link_reg;
    lobm_pkg::link_t link_next;

    logic                       fill_hit;
    logic                       rest_hit;
    logic                       v_opp;
    logic [lobm_pkg::ARR_W-1:0] age;
    logic                       better;

    assign fill_hit = cmd.fill_we && (cmd.fill_idx == lobm_pkg::IDX_W'(SLOT));
    assign rest_hit = cmd.rest_we && (cmd.rest_idx == lobm_pkg::IDX_W'(SLOT));

    always_ff @(posedge clk)
    begin
        if (cmd.ld)
        begin
            cur_price_reg <= price_mem[addr_opp];
            cur_qty_reg   <= qty_mem[addr_opp];
            cur_id_reg    <= id_mem[addr_opp];
            cur_arr_reg   <= arr_mem[addr_opp];
        end
        if (fill_hit)
        begin
            qty_mem[addr_opp] <= cmd.fill_qty;
            cur_qty_reg       <= cmd.fill_qty;
        end
        if (rest_hit)
        begin
            price_mem[addr_own] <= cmd.rest_price;
            qty_mem[addr_own]   <= cmd.rest_qty;
            id_mem[addr_own]    <= cmd.rest_id;
            arr_mem[addr_own]   <= cmd.now;
        end
    end

    always_comb
    begin
        v_opp = valid_reg[addr_opp];
        age   = cmd.now - cur_arr_reg;
        if (!link_in.found)
            better = 1'b1;
        else if (cur_price_reg != link_in.price)
            better = cmd.opp_ask ? (cur_price_reg < link_in.price)
                                 : (cur_price_reg > link_in.price);
        else
            better = age > link_in.age;

        link_next = link_in;
        if (v_opp && better)
        begin
            link_next.found = 1'b1;
            link_next.idx   = lobm_pkg::IDX_W'(SLOT);
            link_next.price = cur_price_reg;
            link_next.age   = age;
            link_next.qty   = cur_qty_reg;
            link_next.id    = cur_id_reg;
        end
        // lowest free slot of the order's own book
        if (!link_in.free_found && !valid_reg[addr_own])
        begin
            link_next.free_found = 1'b1;
            link_next.free_idx   = lobm_pkg::IDX_W'(SLOT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            link_reg  <= '0;
        end
        else
        begin
            link_reg <= link_next;
            if (fill_hit && cmd.fill_clear)
                valid_reg[addr_opp] <= 1'b0;
            if (rest_hit)
                valid_reg[addr_own] <= 1'b1;
        end
    end

    assign link_out = link_reg;

    a_no_double_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(fill_hit && rest_hit))
        else $error("fill and rest hit the same cell at once");
    a_rest_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        rest_hit |-> !valid_reg[addr_own])
        else $error("resting into an occupied slot");
    a_fill_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        fill_hit |-> valid_reg[addr_opp])
        else $error("fill against an empty slot");

endmodule
